[hdl/ttkm_pkg.sv]
// ----------------------------------------------------------------------------
// ttkm_pkg
// Shared types, tree geometry and helper functions of the tournament merge.
// ----------------------------------------------------------------------------
package ttkm_pkg;

  localparam int LANES  = 16;
  localparam int LEVELS = (LANES > 1) ? $clog2(LANES) : 0;
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LIDX_W = (LEVELS > 0) ? LEVELS : 1;

  localparam logic [31:0] TERM_TIME = 32'hFFFF_FFFF;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [3:0]        lane;
    logic              lane_exhausted;
    logic [31:0]       event_time;
    logic [31:0]       event_target;
    logic signed [31:0] event_weight;
  } in_t;

  typedef struct packed {
    logic              popped_valid;
    logic [31:0]       popped_time;
    logic [31:0]       popped_target;
    logic signed [31:0] popped_weight;
    logic [3:0]        popped_lane;
    logic [3:0]        head_lane;
    logic              tree_empty;
  } out_t;

  typedef struct packed {
    logic [31:0]        ev_time;
    logic [31:0]        ev_target;
    logic signed [31:0] ev_weight;
    logic [LIDX_W-1:0]  ev_lane;
  } node_t;

  localparam int NODE_DW = $bits(node_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic merge;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic do_write;
    logic leaf_root;
    logic parent_root;
    logic out_free;
  } status_t;

  // strict order: time, then target, then signed weight
  function automatic logic ev_less(node_t a, node_t b);
    if (a.ev_time != b.ev_time) return a.ev_time < b.ev_time;
    if (a.ev_target != b.ev_target) return a.ev_target < b.ev_target;
    return a.ev_weight < b.ev_weight;
  endfunction

  // low four bits of a lane index, zero extended when the index is narrower
  function automatic logic [3:0] lane4(logic [LIDX_W-1:0] v);
    logic [LIDX_W+3:0] ext;
    ext = {4'b0000, v};
    return ext[3:0];
  endfunction

  // after reset every node is terminal and ties go right, so a node carries
  // the lane of the rightmost leaf below it
  function automatic node_t reset_node(logic [NODE_W-1:0] idx);
    logic [NODE_W:0] k;
    node_t n;
    k = {1'b0, idx};
    for (int d = 0; d < LEVELS; d++) begin
      if (k < (NODE_W+1)'(LEAVES - 1)) begin
        k = (k << 1) + (NODE_W+1)'(2);
      end
    end
    n.ev_time   = TERM_TIME;
    n.ev_target = '0;
    n.ev_weight = '0;
    n.ev_lane   = LIDX_W'(k - (NODE_W+1)'(LEAVES - 1));
    return n;
  endfunction

endpackage

[hdl/ttkm_in_if.sv]
// ----------------------------------------------------------------------------
// ttkm_in_if
// Request channel: valid, ready and one request payload.
// ----------------------------------------------------------------------------
interface ttkm_in_if;
  import ttkm_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/ttkm_out_if.sv]
// ----------------------------------------------------------------------------
// ttkm_out_if
// Result channel: valid, ready and one result payload.
// ----------------------------------------------------------------------------
interface ttkm_out_if;
  import ttkm_pkg::*;

  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/ttkm_ram.sv]
// ----------------------------------------------------------------------------
// ttkm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/ttkm_ctrl.sv]
// ----------------------------------------------------------------------------
// ttkm_ctrl
// Request sequencer: accept, walk the tree one level a cycle, hand off result.
// ----------------------------------------------------------------------------
module ttkm_ctrl
  import ttkm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.do_write && !status.leaf_root) begin
            state_nxt = ST_MERGE;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_MERGE: begin
        if (status.parent_root) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.merge    = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MERGE: cmd.merge = 1'b1;
      ST_FINISH: cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/ttkm_dp.sv]
// ----------------------------------------------------------------------------
// ttkm_dp
// Tree storage, root copy, one merge comparator and the result register.
// ----------------------------------------------------------------------------
module ttkm_dp
  import ttkm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  output status_t status,
  input  in_t     in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  node_t             root_r;
  node_t             cur_r;
  logic [NODE_W-1:0] idx_r;
  logic [NODES-1:0]  valid_r;
  logic              rd_valid_r;
  logic [NODE_W-1:0] rd_addr_r;
  out_t              pop_r;
  out_t              out_r;
  logic              out_valid_r;

  node_t             leaf_c;
  logic [LIDX_W-1:0] leaf_lane_c;
  logic [NODE_W-1:0] leaf_idx_c;
  logic              root_term_c;
  logic              do_write_c;
  node_t             sib_c;
  node_t             merged_c;
  logic [NODE_W-1:0] parent_c;
  logic              we_c;
  logic [NODE_W-1:0] waddr_c;
  node_t             wdata_c;
  logic              re_c;
  logic [NODE_W-1:0] raddr_c;
  logic [NODE_W-1:0] base_c;
  logic [NODE_DW-1:0] ram_q;
  out_t              pop_c;
  out_t              load_c;

  function automatic logic [NODE_W-1:0] sibling(logic [NODE_W-1:0] i);
    return i[0] ? i + NODE_W'(1) : i - NODE_W'(1);
  endfunction

  // request decode
  always_comb begin
    root_term_c = (root_r.ev_time == TERM_TIME);
    if (in_data.req_type == REQ_POP) begin
      leaf_lane_c = root_r.ev_lane;
      do_write_c  = !root_term_c && (32'(root_r.ev_lane) < 32'(LANES));
    end else begin
      leaf_lane_c = LIDX_W'(in_data.lane);
      do_write_c  = 32'(in_data.lane) < 32'(LANES);
    end
    leaf_idx_c = NODE_W'(leaf_lane_c) + NODE_W'(LEAVES - 1);
    leaf_c.ev_lane = leaf_lane_c;
    if (in_data.lane_exhausted || in_data.event_time == TERM_TIME) begin
      leaf_c.ev_time   = TERM_TIME;
      leaf_c.ev_target = '0;
      leaf_c.ev_weight = '0;
    end else begin
      leaf_c.ev_time   = in_data.event_time;
      leaf_c.ev_target = in_data.event_target;
      leaf_c.ev_weight = in_data.event_weight;
    end
  end

  // popped fields as seen before the update
  always_comb begin
    pop_c = '0;
    if (in_data.req_type == REQ_POP) begin
      if (root_term_c) begin
        pop_c.popped_time = TERM_TIME;
      end else begin
        pop_c.popped_valid  = 1'b1;
        pop_c.popped_time   = root_r.ev_time;
        pop_c.popped_target = root_r.ev_target;
        pop_c.popped_weight = root_r.ev_weight;
        pop_c.popped_lane   = lane4(root_r.ev_lane);
      end
    end
  end

  // merge one level: the node on the path against its sibling
  always_comb begin
    sib_c    = rd_valid_r ? node_t'(ram_q) : reset_node(rd_addr_r);
    parent_c = (idx_r - NODE_W'(1)) >> 1;
    if (idx_r[0]) begin
      merged_c = ev_less(cur_r, sib_c) ? cur_r : sib_c;
    end else begin
      merged_c = ev_less(sib_c, cur_r) ? sib_c : cur_r;
    end
  end

  always_comb begin
    base_c  = cmd.merge ? parent_c : leaf_idx_c;
    we_c    = cmd.merge || (cmd.accept && do_write_c);
    waddr_c = base_c;
    wdata_c = cmd.merge ? merged_c : leaf_c;
    re_c    = we_c && (base_c != '0);
    raddr_c = sibling(base_c);
  end

  // result: popped fields plus the root after the update
  always_comb begin
    load_c            = pop_r;
    load_c.head_lane  = lane4(root_r.ev_lane);
    load_c.tree_empty = (root_r.ev_time == TERM_TIME);
  end

  ttkm_ram #(
    .WIDTH (NODE_DW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .re    (re_c),
    .raddr (raddr_c),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      root_r      <= reset_node('0);
      out_valid_r <= 1'b0;
    end else begin
      if (we_c) begin
        valid_r[waddr_c] <= 1'b1;
        if (waddr_c == '0) begin
          root_r <= wdata_c;
        end
      end
      if (re_c) begin
        rd_valid_r <= valid_r[raddr_c];
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re_c) begin
      rd_addr_r <= raddr_c;
    end
    if (we_c) begin
      cur_r <= wdata_c;
      idx_r <= waddr_c;
    end
    if (cmd.accept) begin
      pop_r <= pop_c;
    end
    if (cmd.load_out) begin
      out_r <= load_c;
    end
  end

  assign status.do_write    = do_write_c;
  assign status.leaf_root   = (leaf_idx_c == '0);
  assign status.parent_root = (parent_c == '0);
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/tournament_tree_kway_merge.sv]
// ----------------------------------------------------------------------------
// tournament_tree_kway_merge
// Tournament-tree merge of sorted event streams, one lane leaf per stream.
// ----------------------------------------------------------------------------
// A request runs through the sequencer states in order: the accepting cycle
// writes the leaf, the merge state re-merges the path one tree level at a time
// with a single comparator against the sibling read from the node RAM, and the
// finish state loads the result register. The sequencer then returns to idle,
// so a new request is taken only once the last one is through. A request that
// changes nothing (pop of an empty tree) skips the merge state and goes from
// acceptance straight to the finish state. The next request is taken as soon
// as the sequencer is back in idle, while an earlier result may still wait in
// the output register; a request finishes only once that register is free, so
// a stalled result adds its stall cycles to the next request. Each request
// returns exactly one result: the popped event (all zero for a load, terminal
// time for a pop of an empty tree), the lane now at the root and whether the
// root is terminal.
// ----------------------------------------------------------------------------
module tournament_tree_kway_merge
  import ttkm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ttkm_in_if.sink    in_ch,
  ttkm_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // sequence each request: accept, walk, hand off
  ttkm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold the tree, the root copy and the result register
  ttkm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

  assign in_ch.ready = in_ready;

endmodule

[hdl/ttkm_checker.sv]
// ----------------------------------------------------------------------------
// ttkm_checker
// Port-level checks of the tournament merge, bound to the top level.
// ----------------------------------------------------------------------------
module ttkm_checker
  import ttkm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time: drop ready after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_pop_not_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.popped_valid |-> out_data.popped_time != TERM_TIME)
    else $error("popped a terminal event");

  a_no_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.popped_valid |->
      out_data.popped_target == '0 && out_data.popped_weight == '0 &&
      out_data.popped_lane == '0)
    else $error("stale popped fields without a popped event");

endmodule

bind tournament_tree_kway_merge ttkm_checker u_ttkm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
